[hdl/ffra_pkg.sv]
// Package with shared types and constants for the first-fit range allocator.
package ffra_pkg;

  localparam int unsigned MaxFreeRangesDefault = 64;
  localparam int unsigned AddrWidthDefault     = 32;
  localparam logic [31:0] CapacityReset        = 32'd1048576;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_INIT  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FIT     = 2'd1,
    ST_TABLE_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH,
    S_RESP
  } state_t;

endpackage

[hdl/ffra_table.sv]
// Free-range table memory: offset and size, one write and one read port.
module ffra_table #(
  parameter int unsigned Depth = ffra_pkg::MaxFreeRangesDefault,
  parameter int unsigned Aw    = ffra_pkg::AddrWidthDefault,
  localparam int unsigned Iw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [Iw-1:0] waddr,
  input  logic [Aw-1:0] woff,
  input  logic [Aw-1:0] wsize,
  input  logic [Iw-1:0] raddr,
  output logic [Aw-1:0] roff,
  output logic [Aw-1:0] rsize
);

  logic [2*Aw-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {woff, wsize};
    end
    {roff, rsize} <= mem[raddr];
  end

endmodule

[hdl/first_fit_range_allocator_core.sv]
// Top level of the first-fit range allocator with coalescing.
//
// Usage: a request word (in_mode, in_range_offset, in_range_size) is taken
// at a rising edge where start is high and busy is low. Mode 0 allocates
// the first free range large enough, carving from its low end; mode 1
// frees a range, merging it with adjacent neighbors; mode 2 reloads the
// table with one range from 0 to the capacity register; mode 3 does
// nothing. Exactly one result word follows on out_alloc_offset and
// out_status, marked by out_valid for one cycle. The receiver cannot stall
// and must take the word in that cycle.
// The free table sits in one synchronous memory with a registered read.
// A request scans the table entry by entry (read, then compare) and then
// shifts the tail up or down by one entry where an entry is added or
// removed, each moved entry being read and then written. Init and mode 3
// skip the scan and go through S_FINISH to S_RESP. busy stays high
// through the result cycle.
// cfg_we writes the capacity register; write it only while idle.
// Reset (rst_n low, synchronous) empties the table count and sets the
// capacity to 1048576; the memory is not cleared, entries beyond the count
// are never read.
module first_fit_range_allocator_core #(
  parameter int unsigned MaxFreeRanges = ffra_pkg::MaxFreeRangesDefault,
  parameter int unsigned AddrWidth     = ffra_pkg::AddrWidthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_range_offset,
  input  logic [31:0] in_range_size,
  output logic        out_valid,
  output logic [31:0] out_alloc_offset,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned Iw = (MaxFreeRanges > 1) ? $clog2(MaxFreeRanges) : 1;
  localparam int unsigned Cw = $clog2(MaxFreeRanges + 1);
  localparam logic [Cw-1:0] CountMax = Cw'(MaxFreeRanges);

  typedef logic [AddrWidth-1:0] addr_t;

  ffra_pkg::state_t state_r, state_nxt;

  logic [31:0]   cap_r;
  logic [Cw-1:0] count_r, count_nxt;
  logic [Cw-1:0] pos_r, pos_nxt;
  logic [Cw-1:0] sh_r, sh_nxt;
  logic [1:0]    mode_r;
  addr_t         off_r, size_r;
  addr_t         prev_off_r, prev_size_r, prev_off_nxt, prev_size_nxt;
  addr_t         cur_off_r, cur_size_r, cur_off_nxt, cur_size_nxt;
  logic          found_r, found_nxt;
  logic          shift_up_r, shift_up_nxt;
  addr_t         res_off_r, res_off_nxt;
  logic [1:0]    res_st_r, res_st_nxt;

  // Memory port.
  logic          we;
  logic [Cw-1:0] waddr_w, raddr_w;
  addr_t         woff, wsize, roff, rsize;

  ffra_table #(.Depth(MaxFreeRanges), .Aw(AddrWidth)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr_w[Iw-1:0]),
    .woff  (woff),
    .wsize (wsize),
    .raddr (raddr_w[Iw-1:0]),
    .roff  (roff),
    .rsize (rsize)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffra_pkg::S_IDLE;
      cap_r   <= ffra_pkg::CapacityReset;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ffra_pkg::S_IDLE && start) begin
      mode_r <= in_mode;
      off_r  <= AddrWidth'(in_range_offset);
      size_r <= AddrWidth'(in_range_size);
    end
    pos_r       <= pos_nxt;
    sh_r        <= sh_nxt;
    prev_off_r  <= prev_off_nxt;
    prev_size_r <= prev_size_nxt;
    cur_off_r   <= cur_off_nxt;
    cur_size_r  <= cur_size_nxt;
    found_r     <= found_nxt;
    shift_up_r  <= shift_up_nxt;
    res_off_r   <= res_off_nxt;
    res_st_r    <= res_st_nxt;
  end

  // Free-path decisions based on the scan result.
  logic  at_end, join_next, join_prev;
  addr_t end_off;
  assign at_end    = (pos_r == count_r);
  assign end_off   = off_r + size_r;
  assign join_next = !at_end && (end_off == cur_off_r);
  assign join_prev = (pos_r != '0) && ((prev_off_r + prev_size_r) == off_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffra_pkg::S_IDLE: begin
        if (start) begin
          unique case (ffra_pkg::mode_t'(in_mode))
            ffra_pkg::MODE_ALLOC, ffra_pkg::MODE_FREE: state_nxt = ffra_pkg::S_SCAN_RD;
            ffra_pkg::MODE_INIT, ffra_pkg::MODE_NONE:  state_nxt = ffra_pkg::S_FINISH;
            default: state_nxt = ffra_pkg::S_FINISH;
          endcase
        end
      end
      ffra_pkg::S_SCAN_RD: state_nxt = at_end ? ffra_pkg::S_DECIDE : ffra_pkg::S_SCAN;
      ffra_pkg::S_SCAN: begin
        if (mode_r == ffra_pkg::MODE_ALLOC) begin
          state_nxt = (rsize >= size_r) ? ffra_pkg::S_DECIDE : ffra_pkg::S_SCAN_RD;
        end else begin
          state_nxt = (roff < off_r) ? ffra_pkg::S_SCAN_RD : ffra_pkg::S_DECIDE;
        end
      end
      ffra_pkg::S_DECIDE:   state_nxt = found_nxt ? ffra_pkg::S_SHIFT_RD : ffra_pkg::S_FINISH;
      ffra_pkg::S_SHIFT_RD: state_nxt = ffra_pkg::S_SHIFT_WR;
      ffra_pkg::S_SHIFT_WR: state_nxt = (sh_nxt == pos_r) ? ffra_pkg::S_FINISH
                                                         : ffra_pkg::S_SHIFT_RD;
      ffra_pkg::S_FINISH:   state_nxt = ffra_pkg::S_RESP;
      ffra_pkg::S_RESP:     state_nxt = ffra_pkg::S_IDLE;
      default:              state_nxt = ffra_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control. Shifting: shift_up_r marks an insert and
  // moves entries [pos..count-1] up by one from the top (sh_r walks down to
  // pos); else removal moves [pos+1..count-1] down by one (sh_r walks up).
  // found_r marks that a shift pass is needed; the final write of the new
  // entry happens in S_FINISH for inserts.
  always_comb begin
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    sh_nxt        = sh_r;
    prev_off_nxt  = prev_off_r;
    prev_size_nxt = prev_size_r;
    cur_off_nxt   = cur_off_r;
    cur_size_nxt  = cur_size_r;
    found_nxt     = found_r;
    shift_up_nxt  = shift_up_r;
    res_off_nxt   = res_off_r;
    res_st_nxt    = res_st_r;
    we            = 1'b0;
    waddr_w       = pos_r;
    woff          = '0;
    wsize         = '0;
    raddr_w       = pos_r;
    unique case (state_r)
      ffra_pkg::S_IDLE: begin
        pos_nxt      = '0;
        found_nxt    = 1'b0;
        shift_up_nxt = 1'b0;
        res_off_nxt  = '0;
        res_st_nxt   = ffra_pkg::ST_OK;
      end
      ffra_pkg::S_SCAN_RD: begin
        raddr_w = pos_r;
      end
      ffra_pkg::S_SCAN: begin
        cur_off_nxt  = roff;
        cur_size_nxt = rsize;
        if (mode_r == ffra_pkg::MODE_ALLOC) begin
          if (rsize < size_r) begin
            pos_nxt = pos_r + 1'b1;
          end
        end else if (roff < off_r) begin
          prev_off_nxt  = roff;
          prev_size_nxt = rsize;
          pos_nxt       = pos_r + 1'b1;
        end
      end
      ffra_pkg::S_DECIDE: begin
        found_nxt = 1'b0;
        sh_nxt    = pos_r;
        if (mode_r == ffra_pkg::MODE_ALLOC) begin
          if (at_end) begin
            res_st_nxt = ffra_pkg::ST_NO_FIT;
          end else begin
            res_off_nxt = cur_off_r;
            if (cur_size_r == size_r) begin
              found_nxt = 1'b1;
              sh_nxt    = pos_r + 1'b1;
              count_nxt = count_r - 1'b1;
            end else begin
              we    = 1'b1;
              woff  = cur_off_r + size_r;
              wsize = cur_size_r - size_r;
            end
          end
        end else begin
          if (join_next && join_prev) begin
            we        = 1'b1;
            waddr_w   = pos_r - 1'b1;
            woff      = prev_off_r;
            wsize     = prev_size_r + size_r + cur_size_r;
            found_nxt = 1'b1;
            sh_nxt    = pos_r + 1'b1;
            count_nxt = count_r - 1'b1;
          end else if (join_next) begin
            we    = 1'b1;
            woff  = off_r;
            wsize = cur_size_r + size_r;
          end else if (join_prev) begin
            we      = 1'b1;
            waddr_w = pos_r - 1'b1;
            woff    = prev_off_r;
            wsize   = prev_size_r + size_r;
          end else if (count_r >= CountMax) begin
            res_st_nxt = ffra_pkg::ST_TABLE_FULL;
          end else begin
            shift_up_nxt = 1'b1;
            found_nxt    = 1'b1;
            sh_nxt       = count_r;
            count_nxt    = count_r + 1'b1;
          end
        end
        // Nothing to move when the removed entry is the last one or the
        // insert lands at the end; an insert still writes its entry later.
        if (found_nxt && !shift_up_nxt && sh_nxt == count_r) begin
          found_nxt = 1'b0;
        end
        if (shift_up_nxt && sh_nxt == pos_r) begin
          found_nxt = 1'b0;
        end
        if (!shift_up_nxt && !found_nxt) begin
          sh_nxt = pos_r;
        end
        // pos_r now marks where the shift loop stops: for removal it is the
        // old count (last source index + 1), for insertion it is pos.
        if (found_nxt && !shift_up_nxt) begin
          pos_nxt = count_r;
        end
      end
      ffra_pkg::S_SHIFT_RD: begin
        raddr_w = shift_up_r ? (sh_r - 1'b1) : sh_r;
      end
      ffra_pkg::S_SHIFT_WR: begin
        we      = 1'b1;
        waddr_w = shift_up_r ? sh_r : (sh_r - 1'b1);
        woff    = roff;
        wsize   = rsize;
        sh_nxt  = shift_up_r ? (sh_r - 1'b1) : (sh_r + 1'b1);
      end
      ffra_pkg::S_FINISH: begin
        if (mode_r == ffra_pkg::MODE_INIT) begin
          we        = 1'b1;
          waddr_w   = '0;
          woff      = '0;
          wsize     = AddrWidth'(cap_r);
          count_nxt = Cw'(1);
        end else if (mode_r == ffra_pkg::MODE_FREE && shift_up_r) begin
          we      = 1'b1;
          waddr_w = pos_r;
          woff    = off_r;
          wsize   = size_r;
        end
      end
      ffra_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Outputs.
  always_comb begin
    busy             = (state_r != ffra_pkg::S_IDLE);
    out_valid        = (state_r == ffra_pkg::S_RESP);
    out_alloc_offset = 32'(res_off_r);
    out_status       = res_st_r;
  end

endmodule

[test/testbench.sv]
// Testbench for the first-fit range allocator: directed and random requests with a predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TableDepth = ffra_pkg::MaxFreeRangesDefault;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles = 300;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] range_offset;
    logic [31:0] range_size;
  } request_t;

  typedef struct packed {
    logic [31:0] alloc_offset;
    logic [1:0]  status;
  } answer_t;

  // A pending word is either a request or, when is_cfg is set, a new capacity value.
  typedef struct packed {
    logic        is_cfg;
    logic [31:0] cfg_value;
    request_t    req;
  } pending_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  logic [31:0] in_range_offset;
  logic [31:0] in_range_size;
  logic        out_valid;
  logic [31:0] out_alloc_offset;
  logic [1:0]  out_status;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  first_fit_range_allocator_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_range_offset (in_range_offset),
    .in_range_size   (in_range_size),
    .out_valid       (out_valid),
    .out_alloc_offset(out_alloc_offset),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predictor state: the free table as the block should hold it.
  logic [31:0] model_offsets [TableDepth];
  logic [31:0] model_sizes [TableDepth];
  int unsigned model_count;
  logic [31:0] model_capacity;

  pending_t pending_words[$];
  answer_t  expected_answers[$];
  int unsigned error_count;
  bit stimulus_done;
  int unsigned idle_cycles;

  // Removes entry pos and closes the gap.
  function automatic void table_drop(int unsigned pos);
    for (int unsigned i = pos; i + 1 < model_count; i++) begin
      model_offsets[i] = model_offsets[i + 1];
      model_sizes[i] = model_sizes[i + 1];
    end
    model_count--;
  endfunction

  // Computes the answer of one request and updates the predicted table.
  function automatic answer_t allocator_predict(request_t req);
    answer_t ans;
    int unsigned pos;
    logic [31:0] end_addr;
    bit join_next;
    bit join_prev;
    ans.alloc_offset = '0;
    ans.status = ffra_pkg::ST_OK;
    pos = 0;
    case (req.mode)
      ffra_pkg::MODE_ALLOC: begin
        ans.status = ffra_pkg::ST_NO_FIT;
        for (int unsigned i = 0; i < model_count; i++) begin
          if (model_sizes[i] >= req.range_size) begin
            ans.alloc_offset = model_offsets[i];
            ans.status = ffra_pkg::ST_OK;
            if (model_sizes[i] == req.range_size) begin
              table_drop(i);
            end else begin
              model_offsets[i] = model_offsets[i] + req.range_size;
              model_sizes[i] = model_sizes[i] - req.range_size;
            end
            break;
          end
        end
      end
      ffra_pkg::MODE_FREE: begin
        end_addr = req.range_offset + req.range_size;
        while (pos < model_count && model_offsets[pos] < req.range_offset) pos++;
        join_next = (pos < model_count) && (end_addr == model_offsets[pos]);
        join_prev = (pos > 0) &&
            (32'(model_offsets[pos - 1] + model_sizes[pos - 1]) == req.range_offset);
        if (join_next && join_prev) begin
          model_sizes[pos - 1] = model_sizes[pos - 1] + req.range_size + model_sizes[pos];
          table_drop(pos);
        end else if (join_next) begin
          model_offsets[pos] = req.range_offset;
          model_sizes[pos] = model_sizes[pos] + req.range_size;
        end else if (join_prev) begin
          model_sizes[pos - 1] = model_sizes[pos - 1] + req.range_size;
        end else if (model_count >= TableDepth) begin
          ans.status = ffra_pkg::ST_TABLE_FULL;
        end else begin
          for (int unsigned i = model_count; i > pos; i--) begin
            model_offsets[i] = model_offsets[i - 1];
            model_sizes[i] = model_sizes[i - 1];
          end
          model_offsets[pos] = req.range_offset;
          model_sizes[pos] = req.range_size;
          model_count++;
        end
      end
      ffra_pkg::MODE_INIT: begin
        model_count = 1;
        model_offsets[0] = '0;
        model_sizes[0] = model_capacity;
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  // Driver. Requests go out in bursts; a capacity write waits until every
  // answer is in and then a quiet spell, so the block is idle for it.
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned quiet_cycles;
  bit cfg_wait;
  bit cfg_fire;
  pending_t taken_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
      quiet_cycles <= 0;
      cfg_wait <= 1'b0;
    end else begin
      cfg_fire = 1'b0;
      if (start && !busy) begin
        // The word on the ports was taken at this edge.
        taken_word = pending_words.pop_front();
        expected_answers = {expected_answers, allocator_predict(taken_word.req)};
      end
      if (start && busy) begin
        // Hold the word until it is taken.
      end else if (pending_words.size() == 0) begin
        start <= 1'b0;
      end else if (pending_words[0].is_cfg) begin
        start <= 1'b0;
        if (expected_answers.size() != 0 || (start && !busy) || busy) begin
          quiet_cycles <= 0;
        end else if (quiet_cycles < 8) begin
          quiet_cycles <= quiet_cycles + 1;
        end else begin
          cfg_fire = 1'b1;
          cfg_wdata <= pending_words[0].cfg_value;
          model_capacity = pending_words[0].cfg_value;
          void'(pending_words.pop_front());
          quiet_cycles <= 0;
        end
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else begin
        start <= 1'b1;
        in_mode <= pending_words[0].req.mode;
        in_range_offset <= pending_words[0].req.range_offset;
        in_range_size <= pending_words[0].req.range_size;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
      cfg_we <= cfg_fire;
    end
  end

  // Monitor. Every strobed word is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected word offset=%h status=%0d", $time,
                 out_alloc_offset, out_status);
        error_count++;
      end else begin
        answer_t exp_ans;
        exp_ans = expected_answers.pop_front();
        if (out_alloc_offset !== exp_ans.alloc_offset) begin
          $display("%0t: offset mismatch expected %h actual %h", $time,
                   exp_ans.alloc_offset, out_alloc_offset);
          error_count++;
        end
        if (out_status !== exp_ans.status) begin
          $display("%0t: status mismatch expected %0d actual %0d", $time,
                   exp_ans.status, out_status);
          error_count++;
        end
      end
    end
  end

  // Watchdog counting cycles without any accepted word, result or capacity write.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic void push_request(logic [1:0] mode, logic [31:0] off, logic [31:0] size);
    pending_t p;
    p = '0;
    p.req.mode = mode;
    p.req.range_offset = off;
    p.req.range_size = size;
    pending_words = {pending_words, p};
  endfunction

  function automatic void push_capacity(logic [31:0] value);
    pending_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.cfg_value = value;
    pending_words = {pending_words, p};
  endfunction

  // Random word that tends to hit real boundaries so merges and exact fits happen.
  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 4);
      1: return $urandom;
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(1, 64) * 16;
    endcase
  endfunction

  function automatic logic [31:0] rand_offset();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 64);
      default: return $urandom_range(0, 256) * 16;
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_mode = ffra_pkg::MODE_ALLOC;
    in_range_offset = '0;
    in_range_size = '0;
    model_capacity = ffra_pkg::CapacityReset;
    model_count = 0;
    error_count = 0;
    stimulus_done = 1'b0;

    // Directed part: empty table, reset capacity, exact fits, zero sizes,
    // equal offsets, both-side merges, the unused mode, and a full table.
    push_request(ffra_pkg::MODE_ALLOC, 32'h0, 32'h10);
    push_request(ffra_pkg::MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(ffra_pkg::MODE_INIT, 32'h0, 32'h0);
    push_request(ffra_pkg::MODE_ALLOC, 32'h0, 32'h0);
    push_request(ffra_pkg::MODE_ALLOC, 32'h0, 32'h100);
    push_request(ffra_pkg::MODE_ALLOC, 32'h0, 32'h100);
    push_request(ffra_pkg::MODE_FREE, 32'h0, 32'h100);
    push_request(ffra_pkg::MODE_FREE, 32'h0, 32'h0);
    push_request(ffra_pkg::MODE_FREE, 32'h100, 32'h100);
    push_request(ffra_pkg::MODE_ALLOC, 32'h0, 32'h000F_FFFF);
    push_request(ffra_pkg::MODE_ALLOC, 32'h0, 32'h1);
    push_request(ffra_pkg::MODE_ALLOC, 32'h0, 32'h0);
    push_request(ffra_pkg::MODE_ALLOC, 32'h0, 32'hFFFF_FFFF);
    push_capacity(32'h0);
    push_request(ffra_pkg::MODE_INIT, 32'h0, 32'h0);
    push_request(ffra_pkg::MODE_ALLOC, 32'h0, 32'h0);
    push_capacity(32'hFFFF_FFFF);
    push_request(ffra_pkg::MODE_INIT, 32'h0, 32'h0);
    push_request(ffra_pkg::MODE_FREE, 32'hFFFF_FFFF, 32'h1);
    push_request(ffra_pkg::MODE_ALLOC, 32'h0, 32'hFFFF_FFFF);
    push_request(ffra_pkg::MODE_ALLOC, 32'h0, 32'h1);
    // Fill the table with isolated ranges until it reports full.
    push_capacity(32'h10);
    push_request(ffra_pkg::MODE_INIT, 32'h0, 32'h0);
    for (int i = 0; i < 66; i++) push_request(ffra_pkg::MODE_FREE, 32'h1000 + i * 32, 32'h8);
    push_request(ffra_pkg::MODE_FREE, 32'h1008, 32'h18);
    push_request(ffra_pkg::MODE_FREE, 32'h1028, 32'h4);

    // Random part in phases with different capacities; most traffic is
    // alloc and free requests with random, boundary-leaning offsets and sizes.
    for (int phase = 0; phase < 8; phase++) begin
      push_capacity(phase == 0 ? 32'h0 : (phase == 1 ? 32'hFFFF_FFFF : $urandom_range(1, 8192)));
      push_request(ffra_pkg::MODE_INIT, $urandom, $urandom);
      for (int i = 0; i < 250; i++) begin
        case ($urandom_range(0, 19))
          0: push_request(ffra_pkg::MODE_INIT, $urandom, $urandom);
          1: push_request(ffra_pkg::MODE_NONE, $urandom, $urandom);
          2, 3, 4, 5, 6, 7, 8, 9: push_request(ffra_pkg::MODE_ALLOC, $urandom, rand_size());
          default: push_request(ffra_pkg::MODE_FREE, rand_offset(), rand_size());
        endcase
      end
    end
    push_capacity(ffra_pkg::CapacityReset);
    push_request(ffra_pkg::MODE_INIT, 32'h0, 32'h0);
    push_request(ffra_pkg::MODE_ALLOC, 32'h0, 32'h40);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || expected_answers.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
